// ===== sv/skt_pkg.sv =====
`timescale 1ns / 1ps

package skt_pkg;

    localparam int KEY_W    = 16;
    localparam int ID_W     = 16;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;

    // operation codes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 3'd4;

    typedef struct packed {
        logic            mode;
        logic [ID_W-1:0] entry_id;
        logic [KEY_W-1:0] sort_key;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [COUNT_W-1:0]  entry_count;
    } t_out_item;

    typedef struct packed {
        logic [ID_W-1:0]  entry_id;
        logic [KEY_W-1:0] sort_key;
    } t_entry;

    // per-cell compare results
    typedef struct packed {
        logic match;
        logic le;
    } t_cell_flags;

    // broadcast commit strobes
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctl;

endpackage

// ===== sv/sorted_key_table_insert_remove.sv =====
`timescale 1ns / 1ps

// sorted key table: CAPACITY cells in a row, each holding one (entry_id, sort_key)
// entry, kept in ascending key order with equal keys in arrival order. an insert
// transfer is rejected as duplicate if its id is stored (even when the table is
// full), else as full; otherwise it lands after every entry with key <= its key.
// a remove transfer deletes the matching id and closes the gap, or reports not
// found. each input transfer gives exactly one output transfer: status, position
// touched (0 when rejected) and the entry count afterwards; position and count are
// reported in 4 and 5 bits. an item passes the accept edge, a compare state in
// which every cell compares its entry against the item and registers its flags,
// and an apply state in which all cells shift toward or away from the slot at once.
// no new item is taken while one is in flight; the next is taken the cycle after
// that shift. a result that waits in the output register does not block the next
// input transfer, only the following shift.
module sorted_key_table_insert_remove #(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  skt_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output skt_pkg::t_out_item o_out_data
);
    import skt_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    // one-hot sequencer
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CMP   = 3'b010,
        S_APPLY = 3'b100
    } t_state;

    t_state    r_state;
    t_state    n_state;
    t_in_item  r_item;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic      r_out_valid;
    t_out_item r_out_data;

    t_entry      w_new;
    t_entry      w_entry [CAPACITY];
    t_cell_flags w_flags [CAPACITY];
    logic        w_hit   [CAPACITY+1];
    logic        w_cell_valid [CAPACITY];
    t_cell_ctl   w_ctl;

    logic          apply_go;
    logic          found;
    logic          is_full;
    logic          prev_le;
    logic [IW-1:0] ins_enc;
    logic [IW-1:0] rem_enc;
    t_out_item     n_result;

    assign w_new.entry_id = r_item.entry_id;
    assign w_new.sort_key = r_item.sort_key;
    assign w_hit[0]       = 1'b0;

    // the cell row
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry left_entry;
        t_entry right_entry;
        logic   left_le;

        assign w_cell_valid[g] = (CW'(g) < r_count);

        if (g == 0) begin : g_first
            assign left_entry = w_new;
            assign left_le    = 1'b1;
        end else begin : g_mid
            assign left_entry = w_entry[g-1];
            assign left_le    = w_flags[g-1].le;
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_entry = w_entry[g];
        end else begin : g_inner
            assign right_entry = w_entry[g+1];
        end

        skt_cell u_cell (
            .i_clk        (i_clk),
            .i_valid      (w_cell_valid[g]),
            .i_new        (w_new),
            .i_ctl        (w_ctl),
            .i_left_entry (left_entry),
            .i_right_entry(right_entry),
            .i_left_le    (left_le),
            .i_hit_in     (w_hit[g]),
            .o_entry      (w_entry[g]),
            .o_flags      (w_flags[g]),
            .o_hit_out    (w_hit[g+1])
        );
    end

    // slot of an insert: first cell whose key is above the new one (or first empty);
    // slot of a remove: the single matching cell
    always_comb begin
        ins_enc = '0;
        rem_enc = '0;
        prev_le = 1'b1;
        for (int i = 0; i < CAPACITY; i++) begin
            if (prev_le && !w_flags[i].le) begin
                ins_enc = ins_enc | IW'(i);
            end
            if (w_flags[i].match) begin
                rem_enc = rem_enc | IW'(i);
            end
            prev_le = w_flags[i].le;
        end
    end

    assign found    = w_hit[CAPACITY];
    assign is_full  = (r_count == CAP_CNT);
    // the shift waits until the output register can take the result
    assign apply_go = (r_state == S_APPLY) && (!r_out_valid || !i_out_stall);

    always_comb begin
        w_ctl    = '0;
        n_count  = r_count;
        n_result = '0;
        if (r_item.mode == MODE_INSERT) begin
            if (found) begin
                n_result.status = ST_DUPLICATE;
            end else if (is_full) begin
                n_result.status = ST_FULL;
            end else begin
                n_result.status   = ST_INSERTED;
                n_result.position = POS_W'(ins_enc);
                n_count           = r_count + 1'b1;
                w_ctl.ins         = apply_go;
            end
        end else begin
            if (found) begin
                n_result.status   = ST_REMOVED;
                n_result.position = POS_W'(rem_enc);
                n_count           = r_count - 1'b1;
                w_ctl.rem         = apply_go;
            end else begin
                n_result.status = ST_NOTFOUND;
            end
        end
        n_result.entry_count = COUNT_W'(n_count);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (apply_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (apply_go) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_item <= i_in_data;
        end
        if (apply_go) begin
            r_out_data <= n_result;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== sv/skt_cell.sv =====
`timescale 1ns / 1ps

module skt_cell (
    input  logic                 i_clk,
    input  logic                 i_valid,
    input  skt_pkg::t_entry      i_new,
    input  skt_pkg::t_cell_ctl   i_ctl,
    input  skt_pkg::t_entry      i_left_entry,
    input  skt_pkg::t_entry      i_right_entry,
    input  logic                 i_left_le,
    input  logic                 i_hit_in,
    output skt_pkg::t_entry      o_entry,
    output skt_pkg::t_cell_flags o_flags,
    output logic                 o_hit_out
);
    import skt_pkg::*;

    t_entry      r_entry;
    t_entry      n_entry;
    t_cell_flags r_flags;
    t_cell_flags n_flags;

    always_comb begin
        n_flags.match = i_valid && (r_entry.entry_id == i_new.entry_id);
        n_flags.le    = i_valid && (r_entry.sort_key <= i_new.sort_key);
    end

    // insert: cells past the slot take the left neighbor, the slot takes the new entry
    // remove: the hit cell and all to its right take the right neighbor
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins && !r_flags.le) begin
            n_entry = i_left_le ? i_new : i_left_entry;
        end
        if (i_ctl.rem && (i_hit_in || r_flags.match)) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_flags <= n_flags;
        r_entry <= n_entry;
    end

    assign o_entry   = r_entry;
    assign o_flags   = r_flags;
    assign o_hit_out = i_hit_in || r_flags.match;

endmodule
